// ----- hw/rtl/gvaf_pkg.sv -----
// ----------------------------------------------------------------------------
// gvaf_pkg
// Shared constants and types for the gravity vector attitude filter.
// ----------------------------------------------------------------------------
package gvaf_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int ESTIMATE_WIDTH_DEF = 24;
    localparam logic [15:0] GAIN_RESET = 16'd655;

    // Datapath operations issued by the controller
    localparam logic [3:0] OP_LOAD   = 4'd0;  // latch sample, form angles, save old estimate
    localparam logic [3:0] OP_ROT    = 4'd1;  // one rotation term (step index selects)
    localparam logic [3:0] OP_FUSE   = 4'd2;  // one fusion term (component index)
    localparam logic [3:0] OP_MAG    = 4'd3;  // accumulate |g|^2 term
    localparam logic [3:0] OP_SQRT   = 4'd4;  // one square-root iteration
    localparam logic [3:0] OP_DIVINI = 4'd5;  // start a division
    localparam logic [3:0] OP_DIV    = 4'd6;  // one division bit
    localparam logic [3:0] OP_DIVEND = 4'd7;  // round and store a quotient
    localparam logic [3:0] OP_DOT    = 4'd8;  // accumulate dot term
    localparam logic [3:0] OP_OUT    = 4'd9;  // build the result
    localparam logic [3:0] OP_NOP    = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] idx;
    } gvaf_cmd_t;

    typedef struct packed {
        logic in_window;
        logic mag_zero;
    } gvaf_status_t;

endpackage

// ----- hw/rtl/gvaf_ctrl.sv -----
// ----------------------------------------------------------------------------
// gvaf_ctrl
// Sequencer: steps the datapath through one sample; the schedule depends on the status.
// ----------------------------------------------------------------------------
module gvaf_ctrl #(
    parameter int SQRT_STEPS = 32,
    parameter int DIV_STEPS  = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  out_free,
    input  gvaf_pkg::gvaf_status_t status,
    output gvaf_pkg::gvaf_cmd_t    cmd,
    output logic                  busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROT  = 4'd1;
    localparam logic [3:0] S_FUSE = 4'd2;
    localparam logic [3:0] S_MAG  = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_DINI = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_DEND = 4'd7;
    localparam logic [3:0] S_DOT  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    localparam int CW = $clog2(DIV_STEPS + 1) + 1;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        cmd.op     = gvaf_pkg::OP_NOP;
        cmd.idx    = idx_reg;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                // latch the sample on the accepting edge
                if (start) begin
                    cmd.op     = gvaf_pkg::OP_LOAD;
                    idx_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT: begin
                cmd.op   = gvaf_pkg::OP_ROT;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd5) begin
                    idx_next   = '0;
                    state_next = status.in_window ? S_FUSE : S_MAG;
                end
            end
            S_FUSE: begin
                cmd.op   = gvaf_pkg::OP_FUSE;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd2) begin
                    idx_next   = '0;
                    state_next = S_MAG;
                end
            end
            S_MAG: begin
                cmd.op   = gvaf_pkg::OP_MAG;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd2) begin
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (status.mag_zero) begin
                    state_next = S_DOT;
                end else begin
                    cmd.op   = gvaf_pkg::OP_SQRT;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(SQRT_STEPS - 1)) begin
                        state_next = S_DINI;
                    end
                end
            end
            S_DINI: begin
                cmd.op     = gvaf_pkg::OP_DIVINI;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = gvaf_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_STEPS - 1)) begin
                    state_next = S_DEND;
                end
            end
            S_DEND: begin
                cmd.op   = gvaf_pkg::OP_DIVEND;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd2) begin
                    idx_next   = '0;
                    state_next = S_DOT;
                end else begin
                    state_next = S_DINI;
                end
            end
            S_DOT: begin
                cmd.op   = gvaf_pkg::OP_DOT;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd2) begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.op     = gvaf_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/gvaf_dp.sv -----
// ----------------------------------------------------------------------------
// gvaf_dp
// Datapath: estimate registers, shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
module gvaf_dp #(
    parameter int SAMPLE_WIDTH   = gvaf_pkg::SAMPLE_WIDTH_DEF,
    parameter int ESTIMATE_WIDTH = gvaf_pkg::ESTIMATE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gvaf_pkg::gvaf_cmd_t           cmd,
    input  logic [15:0]                   gain,
    input  logic signed [SAMPLE_WIDTH-1:0] in_acc [3],
    input  logic signed [SAMPLE_WIDTH-1:0] in_rate [3],
    input  logic [15:0]                   in_dt,
    output gvaf_pkg::gvaf_status_t        status,
    output logic signed [15:0]            res_down [3],
    output logic signed [15:0]            res_vert
);

    localparam int EW   = ESTIMATE_WIDTH;
    localparam int SW   = SAMPLE_WIDTH;
    localparam int EF   = EW - 3;
    localparam int AF   = SW - 4;
    localparam int GF   = SW - 6;
    localparam int ASH  = GF + 20 - EF;     // angle shift, may be <= 0
    localparam int PW   = 96;               // wide scratch width
    localparam int M2W  = 2 * EW + 2;       // |g|^2 width
    localparam int RW   = EW + 1;           // sqrt result width
    localparam int NW   = EW + EF + 1;      // dividend magnitude width
    localparam int FSH  = AF - EF;          // accel to estimate shift
    localparam int OSH  = EF - 14;
    localparam int DSH  = EF + AF - 12;
    localparam logic signed [PW-1:0] EMAX = PW'((64'sd1 <<< (EW - 1)) - 1);
    localparam logic signed [PW-1:0] EMIN = -EMAX - 1;
    localparam logic [2*SW+1:0] LO_B = (2*SW+2)'(((64'd9 << (2*AF)) + 64'd9) / 64'd10);
    localparam logic [2*SW+1:0] HI_B = (2*SW+2)'((64'd11 << (2*AF)) / 64'd10);

    logic signed [EW-1:0] g_reg [3];
    logic signed [EW-1:0] old_reg [3];
    logic signed [EW-1:0] ang_reg [3];
    logic signed [SW-1:0] a_reg [3];
    logic                 win_reg;
    logic [M2W-1:0]       m2_reg;
    logic [M2W-1:0]       rem_reg;
    logic [M2W-1:0]       bit_reg;
    logic [M2W-1:0]       root_reg;
    logic [NW-1:0]        num_reg;
    logic [NW-1:0]        q_reg;
    logic [NW+RW:0]       dr_reg;
    logic                 neg_reg;
    logic signed [PW-1:0] dot_reg;
    logic                 zero_reg;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                                 input int s);
        logic [PW-1:0] m;
        begin
            m = v[PW-1] ? PW'(-v) : v;
            if (s > 0) begin
                m = (m + (PW'(1) << (s - 1))) >> s;
            end else begin
                m = m << (-s);
            end
            rnd = v[PW-1] ? -$signed(m) : $signed(m);
        end
    endfunction

    function automatic logic signed [PW-1:0] sat_e(input logic signed [PW-1:0] v);
        sat_e = (v > EMAX) ? EMAX : ((v < EMIN) ? EMIN : v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        sat16 = (v > 96'sd32767) ? 16'sh7FFF : ((v < -96'sd32768) ? 16'sh8000 : v[15:0]);
    endfunction

    // shared multiplier operands
    logic signed [EW:0]   mul_a;
    logic signed [EW+1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [1:0]           dst;
    logic                 subtract;
    logic signed [PW-1:0] acc_sum;
    logic [2*SW+1:0]      am2;
    logic [RW-1:0]        mag;
    logic [NW+RW:0]       dshift;
    logic [NW+RW:0]       trial;

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        dst      = 2'd0;
        subtract = 1'b0;
        unique case (cmd.idx)
            3'd0: begin mul_a = (EW+1)'(ang_reg[0]); mul_b = (EW+2)'(g_reg[0]);
                dst = 2'd2; subtract = 1'b1; end
            3'd1: begin mul_a = (EW+1)'(ang_reg[0]); mul_b = (EW+2)'(g_reg[2]);
                dst = 2'd0; end
            3'd2: begin mul_a = (EW+1)'(ang_reg[1]); mul_b = (EW+2)'(g_reg[2]);
                dst = 2'd1; end
            3'd3: begin mul_a = (EW+1)'(ang_reg[1]); mul_b = (EW+2)'(g_reg[1]);
                dst = 2'd2; subtract = 1'b1; end
            3'd4: begin mul_a = (EW+1)'(ang_reg[2]); mul_b = (EW+2)'(g_reg[1]);
                dst = 2'd0; subtract = 1'b1; end
            3'd5: begin mul_a = (EW+1)'(ang_reg[2]); mul_b = (EW+2)'(g_reg[0]);
                dst = 2'd1; end
            default: ;
        endcase
        if (cmd.op == gvaf_pkg::OP_FUSE) begin
            dst   = cmd.idx[1:0];
            mul_a = (EW+1)'($signed({1'b0, gain}));
            mul_b = (EW+2)'(rnd(PW'(a_reg[cmd.idx[1:0]]), FSH)
                    - PW'(g_reg[cmd.idx[1:0]]));
        end else if (cmd.op == gvaf_pkg::OP_MAG) begin
            mul_a = (EW+1)'(g_reg[cmd.idx[1:0]]);
            mul_b = (EW+2)'(g_reg[cmd.idx[1:0]]);
        end else if (cmd.op == gvaf_pkg::OP_DOT) begin
            mul_a = (EW+1)'(g_reg[cmd.idx[1:0]]);
            mul_b = (EW+2)'(a_reg[cmd.idx[1:0]]);
        end
        prod = PW'(mul_a) * PW'(mul_b);
        if (cmd.op == gvaf_pkg::OP_FUSE) begin
            acc_sum = sat_e(PW'(g_reg[dst]) + rnd(prod, 16));
        end else if (subtract) begin
            acc_sum = sat_e(PW'(g_reg[dst]) - rnd(prod, EF));
        end else begin
            acc_sum = sat_e(PW'(g_reg[dst]) + rnd(prod, EF));
        end
        am2 = (2*SW+2)'(a_reg[0] * a_reg[0]) + (2*SW+2)'(a_reg[1] * a_reg[1])
            + (2*SW+2)'(a_reg[2] * a_reg[2]);
        mag    = RW'(root_reg);
        // shift in the next dividend bit, then try the divisor
        dshift = {dr_reg[NW+RW-1:0], num_reg[NW-1]};
        trial  = dshift - {(NW+1)'(0), mag};
    end

    logic signed [EW-1:0] gsel;
    logic [NW-1:0]        qr;
    logic signed [PW-1:0] qs;
    logic [M2W-1:0]       rb;
    always_comb begin
        gsel = g_reg[cmd.idx[1:0]];
        // quotient rounding: bump when 2*remainder >= divisor
        qr   = q_reg + NW'((dr_reg << 1) >= (NW+RW+1)'(mag));
        qs   = neg_reg ? -$signed(PW'(qr)) : $signed(PW'(qr));
        rb   = root_reg + bit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg[0] <= '0;
            g_reg[1] <= '0;
            g_reg[2] <= EW'(1) << EF;
            old_reg[0] <= '0;
            old_reg[1] <= '0;
            old_reg[2] <= EW'(1) << EF;
            zero_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                gvaf_pkg::OP_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i]   <= in_acc[i];
                        ang_reg[i] <= EW'(rnd(PW'(in_rate[i]) * PW'($signed({1'b0, in_dt})),
                                              ASH));
                        old_reg[i] <= g_reg[i];
                    end
                    win_reg  <= 1'b0;
                    m2_reg   <= '0;
                    dot_reg  <= '0;
                    zero_reg <= 1'b0;
                end
                gvaf_pkg::OP_ROT: begin
                    g_reg[dst] <= EW'(acc_sum);
                    win_reg    <= (am2 >= LO_B) && (am2 <= HI_B);
                end
                gvaf_pkg::OP_FUSE: g_reg[dst] <= EW'(acc_sum);
                gvaf_pkg::OP_MAG: begin
                    m2_reg   <= m2_reg + M2W'(prod);
                    rem_reg  <= m2_reg + M2W'(prod);
                    root_reg <= '0;
                    bit_reg  <= M2W'(1) << (2 * ((M2W - 1) / 2));
                    if (cmd.idx == 3'd2) begin
                        zero_reg <= (m2_reg + M2W'(prod)) == '0;
                        if ((m2_reg + M2W'(prod)) == '0) begin
                            for (int i = 0; i < 3; i++) g_reg[i] <= old_reg[i];
                        end
                    end
                end
                gvaf_pkg::OP_SQRT: begin
                    if (rem_reg >= rb) begin
                        rem_reg  <= rem_reg - rb;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                gvaf_pkg::OP_DIVINI: begin
                    neg_reg <= gsel[EW-1];
                    num_reg <= NW'(gsel[EW-1] ? -PW'(gsel) : PW'(gsel)) << EF;
                    dr_reg  <= '0;
                    q_reg   <= '0;
                end
                gvaf_pkg::OP_DIV: begin
                    // restoring division, one quotient bit per step
                    if (!trial[NW+RW]) begin
                        dr_reg <= trial;
                        q_reg  <= {q_reg[NW-2:0], 1'b1};
                    end else begin
                        dr_reg <= dshift;
                        q_reg  <= {q_reg[NW-2:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                end
                gvaf_pkg::OP_DIVEND: g_reg[cmd.idx[1:0]] <= EW'(sat_e(qs));
                gvaf_pkg::OP_DOT: dot_reg <= dot_reg + prod;
                gvaf_pkg::OP_OUT: begin
                    for (int i = 0; i < 3; i++) res_down[i] <= sat16(rnd(PW'(g_reg[i]), OSH));
                    res_vert <= sat16(rnd(dot_reg, DSH));
                end
                default: ;
            endcase
        end
    end

    assign status.in_window = win_reg;
    assign status.mag_zero  = zero_reg;

endmodule

// ----- hw/rtl/gravity_vector_attitude_filter_unit.sv -----
// ----------------------------------------------------------------------------
// gravity_vector_attitude_filter_unit
// Gravity-vector complementary filter over one IMU sample per request.
// ----------------------------------------------------------------------------
// One sample is worked at a time and is latched on its accepting edge. A
// sample takes a load step, six rotation steps, three fusion steps when
// the accelerometer lies in the window, three magnitude steps,
// ESTIMATE_WIDTH+1 square-root steps, three divisions (each of
// 2*ESTIMATE_WIDTH-2 bit steps plus setup and rounding), three dot steps
// and an output step; when the vector collapses to zero, the square root
// and divisions are skipped. The restoring divider sets most of the time.
// The next sample is taken once the result is in the output register,
// while that result still waits; its output step then holds until the
// waiting result is taken.
module gravity_vector_attitude_filter_unit #(
    parameter int SAMPLE_WIDTH   = gvaf_pkg::SAMPLE_WIDTH_DEF,
    parameter int ESTIMATE_WIDTH = gvaf_pkg::ESTIMATE_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw, time_step
    input  logic [((6*SAMPLE_WIDTH+16+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // down_x, down_y, down_z, vertical_accel
    output logic [63:0]               m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int EW = ESTIMATE_WIDTH;

    logic [15:0]            gain_reg;
    logic                   ovalid_reg;
    logic signed [SW-1:0]   acc [3];
    logic signed [SW-1:0]   rate [3];
    logic signed [15:0]     rd [3];
    logic signed [15:0]     rv;
    gvaf_pkg::gvaf_cmd_t    cmd;
    gvaf_pkg::gvaf_status_t st;
    logic                   busy;
    logic                   start;
    logic                   out_free;

    assign start     = s_tvalid && s_tready;
    assign s_tready  = !busy;
    assign cfg_ready = 1'b1;
    assign out_free  = !ovalid_reg || m_tready;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign acc[i]  = s_tdata[i*SW +: SW];
        assign rate[i] = s_tdata[(3+i)*SW +: SW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= gvaf_pkg::GAIN_RESET;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) gain_reg <= cfg_data;
            if (cmd.op == gvaf_pkg::OP_OUT) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    gvaf_ctrl #(
        .SQRT_STEPS(EW + 1),
        .DIV_STEPS (2 * EW - 2)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .out_free(out_free),
        .status  (st),
        .cmd     (cmd),
        .busy    (busy)
    );

    gvaf_dp #(
        .SAMPLE_WIDTH  (SW),
        .ESTIMATE_WIDTH(EW)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .gain    (gain_reg),
        .in_acc  (acc),
        .in_rate (rate),
        .in_dt   (s_tdata[6*SW +: 16]),
        .status  (st),
        .res_down(rd),
        .res_vert(rv)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {rv, rd[2], rd[1], rd[0]};

endmodule
